// ----- design/dfbc_pkg.sv -----
// ----------------------------------------------------------------------------
// dfbc_pkg
// Shared constants and types for the duplex frame builder and checker.
// ----------------------------------------------------------------------------
package dfbc_pkg;

  localparam int unsigned HDR_BYTES = 9;
  localparam int unsigned SUM_SPAN  = 8;
  localparam int unsigned LEN_W     = 16;
  localparam int unsigned CAP_W     = 7;
  localparam int unsigned BYTE_W    = 8;

  localparam logic [BYTE_W-1:0] FRAME_MAGIC = 8'hA5;
  localparam logic [CAP_W-1:0]  CAP_RESET   = 7'd64;

  // configuration register indexes
  localparam logic CFG_RX_CAPACITY = 1'b0;
  localparam logic CFG_POLL_TYPE   = 1'b1;

  // per-beat slot decode handed to the receive checker
  typedef struct packed {
    logic active;      // slot belongs to a frame
    logic update;      // beat is accepted this cycle
    logic restart;     // a new frame starts in this slot
    logic sum_span;    // slot lies in bytes covered by the checksum
    logic slot_magic;
    logic slot_type;
    logic slot_len_lo;
    logic slot_len_hi;
    logic slot_check;
    logic slot_last;
  } slot_ctl_t;

  typedef struct packed {
    logic              pvalid;
    logic [BYTE_W-1:0] pbyte;
    logic              ok;
    logic [BYTE_W-1:0] rtype;
    logic [CAP_W-1:0]  rlen;
  } rx_res_t;

endpackage

// ----- design/duplex_frame_builder_checker_top.sv -----
// ----------------------------------------------------------------------------
// duplex_frame_builder_checker_top
// Full-duplex fixed-length frame engine, one byte slot per beat.
// ----------------------------------------------------------------------------
// a result beat is registered and appears in the cycle after its input beat is accepted
// throughput: one beat per cycle while out_ready_i does not stall the single output register stage
// the input side stays ready while the output register is empty or drained
// reset: no frame active, capacity 64, poll type 0, output register empty
// ----------------------------------------------------------------------------
module duplex_frame_builder_checker_top #(
  parameter int unsigned PAYLOAD_BYTES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_data_i,

  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        frame_start_i,
  input  logic [7:0]  tx_type_i,
  input  logic [31:0] sequence_req_i,
  input  logic [15:0] tx_length_i,
  input  logic [7:0]  tx_payload_byte_i,
  input  logic [7:0]  rx_byte_i,

  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  tx_byte_o,
  output logic [7:0]  rx_payload_byte_o,
  output logic        rx_payload_valid_o,
  output logic        frame_done_o,
  output logic        rx_ok_o,
  output logic [7:0]  rx_type_o,
  output logic [6:0]  rx_length_o,
  output logic        tx_rejected_o
);

  localparam int unsigned SLOT_W = $clog2(PAYLOAD_BYTES + dfbc_pkg::HDR_BYTES);
  localparam int unsigned PIDX_W = $clog2(PAYLOAD_BYTES + 1);
  localparam int unsigned LAST_SLOT = PAYLOAD_BYTES + dfbc_pkg::HDR_BYTES - 1;

  // configuration
  logic [dfbc_pkg::CAP_W-1:0]  rx_capacity_q;
  logic [dfbc_pkg::BYTE_W-1:0] poll_type_q;

  // frame state
  logic                        active_q;
  logic [SLOT_W-1:0]           slot_q;
  logic [7:0]                  held_type_q;
  logic [31:0]                 held_seq_q;
  logic [PIDX_W-1:0]           held_len_q;
  logic [7:0]                  tx_sum_q;

  // output register
  logic                        out_valid_q;
  logic [7:0]                  tx_byte_q;
  logic [7:0]                  rx_pbyte_q;
  logic                        rx_pvalid_q;
  logic                        frame_done_q;
  logic                        rx_ok_q;
  logic [7:0]                  rx_type_q;
  logic [6:0]                  rx_length_q;
  logic                        tx_rejected_q;

  logic                        accept;
  logic                        rejected;
  logic                        restart;
  logic                        active_eff;
  logic [SLOT_W-1:0]           slot_eff;
  logic [SLOT_W-1:0]           pay_full;
  logic [PIDX_W-1:0]           pay_idx;
  logic                        in_header;
  logic                        slot_last;
  logic [7:0]                  tx_sum_eff;
  logic [15:0]                 len16;
  logic [7:0]                  hdr_byte;
  logic [7:0]                  tx_byte_c;
  dfbc_pkg::slot_ctl_t         ctl;
  dfbc_pkg::rx_res_t           rx_res;

  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign accept     = in_valid_i & in_ready_o;

  assign rejected   = frame_start_i &&
                      (tx_length_i > dfbc_pkg::LEN_W'(PAYLOAD_BYTES));
  assign restart    = frame_start_i & ~rejected;
  assign active_eff = restart | (~frame_start_i & active_q);
  assign slot_eff   = restart ? '0 : slot_q;
  assign pay_full   = slot_eff - SLOT_W'(dfbc_pkg::HDR_BYTES);
  assign pay_idx    = pay_full[PIDX_W-1:0];
  assign in_header  = slot_eff < SLOT_W'(dfbc_pkg::HDR_BYTES);
  assign slot_last  = slot_eff == SLOT_W'(LAST_SLOT);
  assign tx_sum_eff = restart ? '0 : tx_sum_q;
  assign len16      = dfbc_pkg::LEN_W'(held_len_q);

  always_comb begin
    ctl             = '0;
    ctl.active      = active_eff;
    ctl.update      = accept;
    ctl.restart     = restart;
    ctl.sum_span    = slot_eff < SLOT_W'(dfbc_pkg::SUM_SPAN);
    ctl.slot_magic  = slot_eff == SLOT_W'(0);
    ctl.slot_type   = slot_eff == SLOT_W'(1);
    ctl.slot_len_lo = slot_eff == SLOT_W'(6);
    ctl.slot_len_hi = slot_eff == SLOT_W'(7);
    ctl.slot_check  = slot_eff == SLOT_W'(dfbc_pkg::SUM_SPAN);
    ctl.slot_last   = slot_last;
  end

  // header byte by slot, sequence and length little-endian
  always_comb begin
    case (slot_eff[3:0])
      4'd0:    hdr_byte = dfbc_pkg::FRAME_MAGIC;
      4'd1:    hdr_byte = held_type_q;
      4'd2:    hdr_byte = held_seq_q[7:0];
      4'd3:    hdr_byte = held_seq_q[15:8];
      4'd4:    hdr_byte = held_seq_q[23:16];
      4'd5:    hdr_byte = held_seq_q[31:24];
      4'd6:    hdr_byte = len16[7:0];
      4'd7:    hdr_byte = len16[15:8];
      default: hdr_byte = tx_sum_q;
    endcase
  end

  always_comb begin
    tx_byte_c = '0;
    if (active_eff) begin
      if (in_header) begin
        tx_byte_c = hdr_byte;
      end else if (pay_idx < held_len_q) begin
        tx_byte_c = tx_payload_byte_i;
      end
    end
  end

  dfbc_rx_check #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES),
    .PIDX_W        (PIDX_W)
  ) u_rx_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .pay_idx_i     (pay_idx),
    .rx_byte_i     (rx_byte_i),
    .rx_capacity_i (rx_capacity_q),
    .poll_type_i   (poll_type_q),
    .res_o         (rx_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_capacity_q <= dfbc_pkg::CAP_RESET;
      poll_type_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dfbc_pkg::CFG_RX_CAPACITY: rx_capacity_q <= cfg_data_i[dfbc_pkg::CAP_W-1:0];
        dfbc_pkg::CFG_POLL_TYPE:   poll_type_q   <= cfg_data_i;
        default:                   poll_type_q   <= poll_type_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      slot_q      <= '0;
      held_type_q <= '0;
      held_seq_q  <= '0;
      held_len_q  <= '0;
      tx_sum_q    <= '0;
    end else if (accept) begin
      active_q <= active_eff & ~slot_last;
      slot_q   <= (active_eff && !slot_last) ? slot_eff + SLOT_W'(1) : '0;
      if (restart) begin
        held_type_q <= tx_type_i;
        held_seq_q  <= sequence_req_i;
        held_len_q  <= tx_length_i[PIDX_W-1:0];
      end
      if (active_eff && ctl.sum_span) begin
        tx_sum_q <= tx_sum_eff + tx_byte_c;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q   <= 1'b0;
      tx_byte_q     <= '0;
      rx_pbyte_q    <= '0;
      rx_pvalid_q   <= 1'b0;
      frame_done_q  <= 1'b0;
      rx_ok_q       <= 1'b0;
      rx_type_q     <= '0;
      rx_length_q   <= '0;
      tx_rejected_q <= 1'b0;
    end else if (accept) begin
      out_valid_q   <= 1'b1;
      tx_byte_q     <= tx_byte_c;
      rx_pbyte_q    <= rx_res.pbyte;
      rx_pvalid_q   <= rx_res.pvalid;
      frame_done_q  <= active_eff & slot_last;
      rx_ok_q       <= rx_res.ok;
      rx_type_q     <= rx_res.rtype;
      rx_length_q   <= rx_res.rlen;
      tx_rejected_q <= rejected;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign tx_byte_o          = tx_byte_q;
  assign rx_payload_byte_o  = rx_pbyte_q;
  assign rx_payload_valid_o = rx_pvalid_q;
  assign frame_done_o       = frame_done_q;
  assign rx_ok_o            = rx_ok_q;
  assign rx_type_o          = rx_type_q;
  assign rx_length_o        = rx_length_q;
  assign tx_rejected_o      = tx_rejected_q;

  // a rejected start leaves no frame running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && rejected |=> !active_q)
    else $error("rejected start left a frame active");

  // slot counter rests at zero between frames
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> slot_q == '0)
    else $error("slot counter not cleared while idle");

  // verdict fields only on the last slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rx_ok_q || rx_length_q != '0) |-> frame_done_q)
    else $error("verdict outside frame end");

  // a rejected beat carries nothing else
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_rejected_q |-> (tx_byte_q == '0 && !frame_done_q && !rx_pvalid_q))
    else $error("rejected beat with frame output");

  // the frame ends after its last slot is accepted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && active_eff && slot_last |=> !active_q)
    else $error("frame still active after its last slot");

endmodule

// ----- design/dfbc_rx_check.sv -----
// ----------------------------------------------------------------------------
// dfbc_rx_check
// Receive side: collects header fields, checks magic, checksum and length,
// passes payload bytes up to capacity and forms the frame verdict.
// ----------------------------------------------------------------------------
module dfbc_rx_check #(
  parameter int unsigned PAYLOAD_BYTES = 64,
  parameter int unsigned PIDX_W        = $clog2(PAYLOAD_BYTES + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  dfbc_pkg::slot_ctl_t            ctl_i,
  input  logic [PIDX_W-1:0]              pay_idx_i,
  input  logic [dfbc_pkg::BYTE_W-1:0]    rx_byte_i,
  input  logic [dfbc_pkg::CAP_W-1:0]     rx_capacity_i,
  input  logic [dfbc_pkg::BYTE_W-1:0]    poll_type_i,
  output dfbc_pkg::rx_res_t              res_o
);

  logic [dfbc_pkg::BYTE_W-1:0] sum_q;
  logic                        magic_q;
  logic [dfbc_pkg::BYTE_W-1:0] type_q;
  logic [dfbc_pkg::LEN_W-1:0]  len_q;
  logic                        good_q;

  logic [dfbc_pkg::BYTE_W-1:0] sum_eff;
  logic [dfbc_pkg::LEN_W-1:0]  len_eff;
  logic                        good_eff;
  logic [dfbc_pkg::CAP_W-1:0]  pass_cnt;
  logic                        upd;
  logic                        in_payload;

  assign upd      = ctl_i.update & ctl_i.active;
  assign sum_eff  = ctl_i.restart ? '0 : sum_q;
  assign len_eff  = ctl_i.restart ? '0 : len_q;
  assign good_eff = ctl_i.restart ? 1'b0 : good_q;

  // min(length, capacity) always fits the capacity width
  assign pass_cnt = (len_eff < dfbc_pkg::LEN_W'(rx_capacity_i)) ?
                    len_eff[dfbc_pkg::CAP_W-1:0] : rx_capacity_i;

  assign in_payload = ~ctl_i.sum_span & ~ctl_i.slot_check;

  always_comb begin
    res_o = '0;
    if (ctl_i.active) begin
      if (in_payload && good_eff &&
          (dfbc_pkg::LEN_W'(pay_idx_i) < dfbc_pkg::LEN_W'(pass_cnt))) begin
        res_o.pvalid = 1'b1;
        res_o.pbyte  = rx_byte_i;
      end
      if (ctl_i.slot_last) begin
        res_o.ok    = good_eff;
        res_o.rtype = good_eff ? type_q : poll_type_i;
        res_o.rlen  = good_eff ? pass_cnt : '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      magic_q <= 1'b0;
      type_q  <= '0;
      len_q   <= '0;
      good_q  <= 1'b0;
    end else if (upd) begin
      if (ctl_i.restart) begin
        type_q <= '0;
        len_q  <= '0;
        good_q <= 1'b0;
      end
      if (ctl_i.sum_span) begin
        sum_q <= sum_eff + rx_byte_i;
      end
      if (ctl_i.slot_magic) begin
        magic_q <= (rx_byte_i == dfbc_pkg::FRAME_MAGIC);
      end
      if (ctl_i.slot_type) begin
        type_q <= rx_byte_i;
      end
      if (ctl_i.slot_len_lo) begin
        len_q <= dfbc_pkg::LEN_W'(rx_byte_i);
      end
      if (ctl_i.slot_len_hi) begin
        len_q <= {rx_byte_i, len_eff[dfbc_pkg::BYTE_W-1:0]};
      end
      if (ctl_i.slot_check) begin
        good_q <= magic_q && (rx_byte_i == sum_q) &&
                  (len_q <= dfbc_pkg::LEN_W'(PAYLOAD_BYTES));
      end
    end
  end

endmodule
